// ===== design/fslot_pkg.sv =====
// fslot_pkg: types, constants and codes shared by the frame slot manager
// no dependencies

`default_nettype none

package fslot_pkg;

   localparam int SLOTS     = 4;
   localparam int PARTS     = 128;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int PART_W    = $clog2(PARTS);
   localparam int CNT_W     = PART_W + 1;
   localparam int MEM_DEPTH = SLOTS * PARTS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd1;

   localparam logic [19:0] MAX_BYTES_RST = 20'd65536;
   localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

   localparam logic [7:0] SOI_FIRST  = 8'hFF;
   localparam logic [7:0] SOI_SECOND = 8'hD8;

   typedef enum logic [2:0] {
      FUNC_START   = 3'd0,
      FUNC_ADD     = 3'd1,
      FUNC_COMMIT  = 3'd2,
      FUNC_DISCARD = 3'd3,
      FUNC_GET     = 3'd4,
      FUNC_RELEASE = 3'd5,
      FUNC_TICK    = 3'd6,
      FUNC_QUERY   = 3'd7
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] frame_number;
      logic [7:0]  part_number;
      logic [19:0] part_bytes;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [3:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  slot_out;
      logic [31:0] frame_out;
      logic [19:0] size_out;
      logic [31:0] stamp_out;
      logic [4:0]  complete_count;
      logic [23:0] bytes_used;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_SWEEP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic exec;
      logic sweep;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_op;
      logic sweep_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/frame_slot_manager.sv =====
// frame_slot_manager: top level, joins the sequencer and the slot datapath
// depends on fslot_pkg, fslot_ctrl, fslot_dp
//
//   channel   ports                                  handshake
//   request   start, busy, req_data                  taken when start and not busy
//   result    rsp_valid, rsp_data                    one-cycle strobe, no backpressure
//   config    csr_we, csr_index, csr_wdata           written when csr_we is high
//
// every word except start_frame goes from accept to the next accept through the steps
// latch, part map read or lock aging, execute and result; the strobe is shown in the result step
// start_frame: its part map row is swept one entry a cycle between execute and result
// after reset the whole part map (SLOTS * PARTS entries) is swept, busy is high
// results are shown for one cycle only, the receiver cannot stall them

`default_nettype none

module frame_slot_manager (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire fslot_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   output fslot_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [fslot_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fslot_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   fslot_pkg::ctrl_cmd_type  cmd;
   fslot_pkg::dp_status_type status;

   fslot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fslot_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule

`default_nettype wire

// ===== design/fslot_ctrl.sv =====
// fslot_ctrl: sequencing state machine of the frame slot manager
// depends on fslot_pkg

`default_nettype none

module fslot_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire fslot_pkg::dp_status_type status,
   output fslot_pkg::ctrl_cmd_type      cmd,
   output logic                         busy,
   output logic                         rsp_valid
);

   fslot_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fslot_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         fslot_pkg::ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = fslot_pkg::ST_IDLE;
            end
         end
         fslot_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = fslot_pkg::ST_FETCH;
            end
         end
         fslot_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = fslot_pkg::ST_EXEC;
         end
         fslot_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.start_op ? fslot_pkg::ST_SWEEP : fslot_pkg::ST_RESP;
         end
         fslot_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = fslot_pkg::ST_RESP;
            end
         end
         fslot_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = fslot_pkg::ST_IDLE;
         end
         default: begin
            state_in = fslot_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/fslot_dp.sv =====
// fslot_dp: slot tables, part map memory, config registers and result word
// depends on fslot_pkg

`default_nettype none

module fslot_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fslot_pkg::req_type                   req_data,
   input  wire logic                                 csr_we,
   input  wire logic [fslot_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fslot_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire fslot_pkg::ctrl_cmd_type              cmd,
   output fslot_pkg::dp_status_type                  status,
   output fslot_pkg::rsp_type                        rsp_data
);

   localparam int SW = fslot_pkg::SLOT_W;
   localparam int PW = fslot_pkg::PART_W;
   localparam int CW = fslot_pkg::CNT_W;
   localparam int AW = fslot_pkg::ADDR_W;
   localparam int NS = fslot_pkg::SLOTS;

   fslot_pkg::req_type req_ff, req_in;
   fslot_pkg::rsp_type rsp_ff, rsp_in;

   logic [19:0] max_bytes_ff;
   logic [15:0] timeout_ff;

   logic [NS-1:0] writing_ff, writing_in;
   logic [NS-1:0] complete_ff, complete_in;
   logic [NS-1:0] locked_ff, locked_in;
   logic [NS-1:0] seen0_ff, seen0_in;
   logic [31:0]   frame_ff [NS];
   logic [31:0]   frame_in [NS];
   logic [19:0]   size_ff [NS];
   logic [19:0]   size_in [NS];
   logic [31:0]   stamp_ff [NS];
   logic [31:0]   stamp_in [NS];
   logic [31:0]   lock_time_ff [NS];
   logic [31:0]   lock_time_in [NS];
   logic [CW-1:0] count_ff [NS];
   logic [CW-1:0] count_in [NS];
   logic [PW-1:0] top_ff [NS];
   logic [PW-1:0] top_in [NS];

   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic          newest_vld_ff, newest_vld_in;
   logic [31:0]   last_served_ff, last_served_in;
   logic [31:0]   tick_ff, tick_in;
   logic [20:0]   total_ff, total_in;
   logic [15:0]   header_ff, header_in;
   logic [19:0]   head_len_ff, head_len_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] clr_end_ff, clr_end_in;

   logic          part_map [fslot_pkg::MEM_DEPTH];
   logic          seen_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic          mem_wd;
   logic [AW-1:0] rd_addr;

   logic          avail;
   logic [4:0]    n_complete;
   logic [23:0]   bytes_sum;

   assign rsp_data          = rsp_ff;
   assign status.start_op   = (req_ff.func == fslot_pkg::FUNC_START);
   assign status.sweep_done = (clr_addr_ff == clr_end_ff);
   assign rd_addr = AW'(int'(write_slot_ff) * fslot_pkg::PARTS
                        + int'(req_ff.part_number[PW-1:0]));

   // newest frame that is complete, unlocked and not yet served
   assign avail = newest_vld_ff && complete_ff[newest_ff] && !locked_ff[newest_ff]
                  && (frame_ff[newest_ff] > last_served_ff);

   always_comb begin
      n_complete = '0;
      bytes_sum  = '0;
      for (int i = 0; i < NS; i++) begin
         if (complete_ff[i]) begin
            n_complete = n_complete + 5'd1;
            bytes_sum  = bytes_sum + 24'(size_ff[i]);
         end
      end
   end

   always_comb begin
      logic          found;
      logic [SW-1:0] idx;
      logic [SW:0]   cand;
      logic [SW-1:0] w;
      logic [20:0]   sum;
      logic          valid_run;

      req_in         = req_ff;
      rsp_in         = rsp_ff;
      writing_in     = writing_ff;
      complete_in    = complete_ff;
      locked_in      = locked_ff;
      seen0_in       = seen0_ff;
      frame_in       = frame_ff;
      size_in        = size_ff;
      stamp_in       = stamp_ff;
      lock_time_in   = lock_time_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      write_slot_in  = write_slot_ff;
      newest_in      = newest_ff;
      newest_vld_in  = newest_vld_ff;
      last_served_in = last_served_ff;
      tick_in        = tick_ff;
      total_in       = total_ff;
      header_in      = header_ff;
      head_len_in    = head_len_ff;
      clr_addr_in    = clr_addr_ff;
      clr_end_in     = clr_end_ff;
      mem_we         = 1'b0;
      mem_wa         = clr_addr_ff;
      mem_wd         = 1'b0;
      found          = 1'b0;
      idx            = write_slot_ff;
      cand           = '0;
      w              = write_slot_ff;
      sum            = total_ff + 21'(req_ff.part_bytes);
      valid_run      = (count_ff[w] != '0) && (count_ff[w] == ({1'b0, top_ff[w]} + CW'(1)));

      if (cmd.load) begin
         req_in = req_data;
      end

      // stale read locks go before a new frame is opened
      if (cmd.fetch && (req_ff.func == fslot_pkg::FUNC_START)) begin
         for (int i = 0; i < NS; i++) begin
            if (locked_ff[i] && ((tick_ff - lock_time_ff[i]) > 32'(timeout_ff))) begin
               locked_in[i] = 1'b0;
            end
         end
      end

      if (cmd.exec) begin
         rsp_in = '0;
         case (req_ff.func)
            fslot_pkg::FUNC_START: begin
               for (int k = 0; k < NS; k++) begin
                  cand = {1'b0, write_slot_ff} + (SW+1)'(k);
                  if (cand >= (SW+1)'(NS)) begin
                     cand = cand - (SW+1)'(NS);
                  end
                  if (!found && !locked_ff[cand[SW-1:0]]
                      && !(newest_vld_ff && (cand[SW-1:0] == newest_ff))) begin
                     found = 1'b1;
                     idx   = cand[SW-1:0];
                  end
               end
               for (int k = 0; k < NS; k++) begin
                  cand = {1'b0, write_slot_ff} + (SW+1)'(k);
                  if (cand >= (SW+1)'(NS)) begin
                     cand = cand - (SW+1)'(NS);
                  end
                  if (!found && !locked_ff[cand[SW-1:0]]) begin
                     found = 1'b1;
                     idx   = cand[SW-1:0];
                  end
               end
               size_in[idx]     = '0;
               frame_in[idx]    = req_ff.frame_number;
               writing_in[idx]  = 1'b1;
               complete_in[idx] = 1'b0;
               seen0_in[idx]    = 1'b0;
               count_in[idx]    = '0;
               top_in[idx]      = '0;
               total_in         = '0;
               header_in        = '0;
               head_len_in      = '0;
               write_slot_in    = idx;
               clr_addr_in      = AW'(int'(idx) * fslot_pkg::PARTS);
               clr_end_in       = AW'(int'(idx) * fslot_pkg::PARTS + fslot_pkg::PARTS - 1);
               rsp_in.ok        = 1'b1;
               rsp_in.slot_out  = 4'(idx);
            end
            fslot_pkg::FUNC_ADD: begin
               if (({1'b0, req_ff.part_number} < 9'(fslot_pkg::PARTS))
                   && (req_ff.part_bytes != '0) && writing_ff[w]) begin
                  if (seen_rd_ff) begin
                     rsp_in.ok = 1'b1;
                  end else if (sum <= {1'b0, max_bytes_ff}) begin
                     total_in = sum;
                     if (req_ff.part_number == 8'd0) begin
                        header_in[7:0] = req_ff.first_byte;
                        if (req_ff.part_bytes >= 20'd2) begin
                           header_in[15:8] = req_ff.second_byte;
                        end
                        head_len_in = req_ff.part_bytes;
                        seen0_in[w] = 1'b1;
                     end else if (req_ff.part_number == 8'd1) begin
                        if (!(seen0_ff[w] && (head_len_ff >= 20'd2))) begin
                           header_in[15:8] = req_ff.first_byte;
                        end
                     end
                     count_in[w] = count_ff[w] + CW'(1);
                     if (req_ff.part_number[PW-1:0] > top_ff[w]) begin
                        top_in[w] = req_ff.part_number[PW-1:0];
                     end
                     mem_we    = 1'b1;
                     mem_wa    = rd_addr;
                     mem_wd    = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
               end
            end
            fslot_pkg::FUNC_COMMIT: begin
               rsp_in.slot_out = 4'(w);
               if (writing_ff[w]) begin
                  writing_in[w]  = 1'b0;
                  complete_in[w] = 1'b0;
                  if (valid_run) begin
                     size_in[w] = total_ff[19:0];
                     if ((total_ff >= 21'd2) && (header_ff[7:0] == fslot_pkg::SOI_FIRST)
                         && (header_ff[15:8] == fslot_pkg::SOI_SECOND)) begin
                        complete_in[w]  = 1'b1;
                        stamp_in[w]     = tick_ff;
                        newest_in       = w;
                        newest_vld_in   = 1'b1;
                        write_slot_in   = ({1'b0, w} == (SW+1)'(NS - 1)) ? '0 : w + SW'(1);
                        rsp_in.ok       = 1'b1;
                        rsp_in.size_out = total_ff[19:0];
                     end
                  end
               end
            end
            fslot_pkg::FUNC_DISCARD: begin
               writing_in[w]   = 1'b0;
               complete_in[w]  = 1'b0;
               size_in[w]      = '0;
               rsp_in.ok       = 1'b1;
               rsp_in.slot_out = 4'(w);
            end
            fslot_pkg::FUNC_GET: begin
               if (avail) begin
                  locked_in[newest_ff]    = 1'b1;
                  lock_time_in[newest_ff] = tick_ff;
                  last_served_in          = frame_ff[newest_ff];
                  rsp_in.ok               = 1'b1;
                  rsp_in.slot_out         = 4'(newest_ff);
                  rsp_in.frame_out        = frame_ff[newest_ff];
                  rsp_in.size_out         = size_ff[newest_ff];
                  rsp_in.stamp_out        = stamp_ff[newest_ff];
               end
            end
            fslot_pkg::FUNC_RELEASE: begin
               if ({1'b0, req_ff.slot_in} < 5'(NS)) begin
                  locked_in[req_ff.slot_in[SW-1:0]] = 1'b0;
                  rsp_in.ok       = 1'b1;
                  rsp_in.slot_out = req_ff.slot_in;
               end
            end
            fslot_pkg::FUNC_TICK: begin
               tick_in   = tick_ff + 32'd1;
               rsp_in.ok = 1'b1;
            end
            fslot_pkg::FUNC_QUERY: begin
               rsp_in.ok             = avail;
               rsp_in.complete_count = n_complete;
               rsp_in.bytes_used     = bytes_sum;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end

      if (cmd.sweep) begin
         mem_we      = 1'b1;
         mem_wa      = clr_addr_ff;
         mem_wd      = 1'b0;
         clr_addr_in = clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         part_map[mem_wa] <= mem_wd;
      end
      if (cmd.fetch) begin
         seen_rd_ff <= part_map[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= fslot_pkg::MAX_BYTES_RST;
         timeout_ff   <= fslot_pkg::TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            fslot_pkg::CSR_MAX_BYTES: max_bytes_ff <= csr_wdata[19:0];
            fslot_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         writing_ff     <= '0;
         complete_ff    <= '0;
         locked_ff      <= '0;
         seen0_ff       <= '0;
         for (int i = 0; i < NS; i++) begin
            frame_ff[i] <= '0;
            size_ff[i]  <= '0;
            count_ff[i] <= '0;
            top_ff[i]   <= '0;
         end
         write_slot_ff  <= '0;
         newest_ff      <= '0;
         newest_vld_ff  <= 1'b0;
         last_served_ff <= '0;
         tick_ff        <= '0;
         total_ff       <= '0;
         header_ff      <= '0;
         head_len_ff    <= '0;
         clr_addr_ff    <= '0;
         clr_end_ff     <= AW'(fslot_pkg::MEM_DEPTH - 1);
      end else begin
         writing_ff     <= writing_in;
         complete_ff    <= complete_in;
         locked_ff      <= locked_in;
         seen0_ff       <= seen0_in;
         frame_ff       <= frame_in;
         size_ff        <= size_in;
         count_ff       <= count_in;
         top_ff         <= top_in;
         write_slot_ff  <= write_slot_in;
         newest_ff      <= newest_in;
         newest_vld_ff  <= newest_vld_in;
         last_served_ff <= last_served_in;
         tick_ff        <= tick_in;
         total_ff       <= total_in;
         header_ff      <= header_in;
         head_len_ff    <= head_len_in;
         clr_addr_ff    <= clr_addr_in;
         clr_end_ff     <= clr_end_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      stamp_ff     <= stamp_in;
      lock_time_ff <= lock_time_in;
   end

endmodule

`default_nettype wire

// ===== tb/fslot_checker.sv =====
// fslot_checker: watches the request, result and config channels of frame_slot_manager,
// predicts each result word from its own slot model and compares field by field
// depends on fslot_pkg
`timescale 1ns / 100ps

module fslot_checker
   import fslot_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   localparam logic [4:0] NO_SLOT = 5'd31;

   logic [19:0] max_bytes;
   logic [15:0] timeout;
   logic        writing  [SLOTS];
   logic        complete [SLOTS];
   logic        locked   [SLOTS];
   logic [31:0] frame_of [SLOTS];
   logic [19:0] size_of  [SLOTS];
   logic [31:0] stamp_of [SLOTS];
   logic [31:0] lock_at  [SLOTS];
   logic        seen     [SLOTS][PARTS];
   logic [3:0]  wslot;
   logic [4:0]  newest;
   logic [31:0] served;
   logic [31:0] ticks;
   logic [20:0] total;
   logic [15:0] header;
   logic [19:0] head_len;

   rsp_type expected_words[$];

   assign pending = expected_words.size();

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic bit newest_ready();
      if (newest >= SLOTS) return 0;
      if (!complete[newest[3:0]] || locked[newest[3:0]]) return 0;
      return frame_of[newest[3:0]] > served;
   endfunction

   task automatic reset_model();
      max_bytes = MAX_BYTES_RST;
      timeout   = TIMEOUT_RST;
      for (int i = 0; i < SLOTS; i++) begin
         writing[i] = 0; complete[i] = 0; locked[i] = 0;
         frame_of[i] = 0; size_of[i] = 0; stamp_of[i] = 0; lock_at[i] = 0;
         for (int p = 0; p < PARTS; p++) seen[i][p] = 0;
      end
      wslot = 0; newest = NO_SLOT; served = 0; ticks = 0;
      total = 0; header = 0; head_len = 0;
   endtask

   task automatic predict_word(input req_type r, output rsp_type e);
      int idx, top, n;
      bit found, good;
      logic [31:0] age;
      logic [23:0] sum;
      e = '0;
      case (func_type'(r.func))
         FUNC_START: begin
            for (int i = 0; i < SLOTS; i++) begin
               age = ticks - lock_at[i];
               if (locked[i] && age > {16'd0, timeout}) locked[i] = 0;
            end
            idx = wslot; found = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!locked[idx] && idx != newest) begin
                  found = 1;
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
            if (!found) begin
               idx = wslot;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!locked[idx]) break;
                  idx = (idx + 1) % SLOTS;
               end
            end
            size_of[idx] = 0; frame_of[idx] = r.frame_number;
            writing[idx] = 1; complete[idx] = 0;
            for (int p = 0; p < PARTS; p++) seen[idx][p] = 0;
            total = 0; header = 0; head_len = 0; wslot = 4'(idx);
            e.ok = 1; e.slot_out = 4'(idx);
         end
         FUNC_ADD: begin
            if (r.part_number < PARTS && r.part_bytes != 0 && writing[wslot]) begin
               if (seen[wslot][r.part_number]) e.ok = 1;
               else if (total + r.part_bytes <= {1'b0, max_bytes}) begin
                  total += r.part_bytes;
                  if (r.part_number == 0) begin
                     header[7:0] = r.first_byte;
                     if (r.part_bytes >= 2) header[15:8] = r.second_byte;
                     head_len = r.part_bytes;
                  end else if (r.part_number == 1) begin
                     if (!(seen[wslot][0] && head_len >= 2)) header[15:8] = r.first_byte;
                  end
                  seen[wslot][r.part_number] = 1;
                  e.ok = 1;
               end
            end
         end
         FUNC_COMMIT: begin
            e.slot_out = wslot;
            if (writing[wslot]) begin
               top = -1;
               for (int p = PARTS - 1; p >= 0; p--)
                  if (seen[wslot][p]) begin
                     top = p;
                     break;
                  end
               good = top >= 0;
               for (int p = 0; p <= top; p++) if (!seen[wslot][p]) good = 0;
               if (good) size_of[wslot] = total[19:0];
               if (good && total >= 2 && header[7:0] == SOI_FIRST
                   && header[15:8] == SOI_SECOND) begin
                  complete[wslot] = 1; stamp_of[wslot] = ticks; writing[wslot] = 0;
                  newest = {1'b0, wslot};
                  e.ok = 1; e.size_out = size_of[wslot];
                  wslot = 4'((wslot + 1) % SLOTS);
               end else begin
                  writing[wslot] = 0; complete[wslot] = 0;
               end
            end
         end
         FUNC_DISCARD: begin
            writing[wslot] = 0; complete[wslot] = 0; size_of[wslot] = 0;
            e.ok = 1; e.slot_out = wslot;
         end
         FUNC_GET: begin
            if (newest_ready()) begin
               idx = newest;
               locked[idx] = 1; lock_at[idx] = ticks; served = frame_of[idx];
               e.ok = 1; e.slot_out = 4'(idx); e.frame_out = frame_of[idx];
               e.size_out = size_of[idx]; e.stamp_out = stamp_of[idx];
            end
         end
         FUNC_RELEASE: begin
            if (r.slot_in < SLOTS) begin
               locked[r.slot_in] = 0;
               e.ok = 1; e.slot_out = r.slot_in;
            end
         end
         FUNC_TICK: begin
            ticks++;
            e.ok = 1;
         end
         default: begin
            n = 0; sum = 0;
            for (int i = 0; i < SLOTS; i++)
               if (complete[i]) begin
                  n++;
                  sum += 24'(size_of[i]);
               end
            e.ok = newest_ready(); e.complete_count = 5'(n); e.bytes_used = sum;
         end
      endcase
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type e, g;
      if (reset) begin
         reset_model();
         expected_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MAX_BYTES) max_bytes = csr_wdata;
            else if (csr_index == CSR_TIMEOUT) timeout = csr_wdata[15:0];
         end
         if (rsp_valid) begin
            g = rsp_data;
            if (expected_words.size() == 0) begin
               report("unexpected result word", 32'd1, 32'd0);
            end else begin
               e = expected_words.pop_front();
               if (g.ok !== e.ok) report("ok", g.ok, e.ok);
               if (g.slot_out !== e.slot_out) report("slot_out", g.slot_out, e.slot_out);
               if (g.frame_out !== e.frame_out) report("frame_out", g.frame_out, e.frame_out);
               if (g.size_out !== e.size_out) report("size_out", g.size_out, e.size_out);
               if (g.stamp_out !== e.stamp_out) report("stamp_out", g.stamp_out, e.stamp_out);
               if (g.complete_count !== e.complete_count)
                  report("complete_count", g.complete_count, e.complete_count);
               if (g.bytes_used !== e.bytes_used)
                  report("bytes_used", g.bytes_used, e.bytes_used);
            end
         end
         if (start && !busy) begin
            predict_word(req_data, e);
            expected_words.push_back(e);
         end
      end
   end

endmodule

// ===== tb/tb_frame_slot_manager.sv =====
// tb_frame_slot_manager: drives command words and register writes into
// frame_slot_manager and gives the verdict; depends on fslot_pkg, frame_slot_manager, fslot_checker
`timescale 1ns / 100ps

module tb_frame_slot_manager;
   import fslot_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   int                    cycles = 0;
   int                    sent = 0;
   bit                    quiet_tail = 0;
   logic [31:0]           frame_seq = 1;

   frame_slot_manager DUT (.*);

   fslot_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input req_type r);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start    <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
      sent++;
      @(posedge clock);
   endtask

   task automatic op(input func_type f, input logic [31:0] frame = 0, input logic [7:0] part = 0,
                     input logic [19:0] len = 0, input logic [7:0] b0 = 0,
                     input logic [7:0] b1 = 0, input logic [3:0] slot = 0);
      req_type r;
      r.func = f; r.frame_number = frame; r.part_number = part; r.part_bytes = len;
      r.first_byte = b0; r.second_byte = b1; r.slot_in = slot;
      send_word(r);
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain();
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_noise();
      req_type r;
      r = req_type'(83'({$urandom, $urandom, $urandom}));
      r.part_bytes = ($urandom_range(0, 3) == 0) ? r.part_bytes : 20'($urandom_range(0, 600));
      send_word(r);
   endtask

   // mostly well-formed frames with random faults, consumer polls and ticks
   task automatic random_frame();
      int n;
      n = $urandom_range(1, 4);
      op(FUNC_START, frame_seq + $urandom_range(0, 3));
      frame_seq += $urandom_range(1, 3);
      for (int p = 0; p < n; p++) begin
         if ($urandom_range(0, 15) == 0) continue;
         op(FUNC_ADD, 0, 8'(p), 20'($urandom_range(1, 400)),
            ($urandom_range(0, 7) == 0) ? 8'($urandom) : SOI_FIRST,
            ($urandom_range(0, 7) == 0) ? 8'($urandom) : SOI_SECOND);
         if ($urandom_range(0, 9) == 0) begin
            op(FUNC_ADD, 0, 8'(p), 20'($urandom_range(1, 400)), 8'($urandom), 8'($urandom));
         end
      end
      if ($urandom_range(0, 9) == 0) op(FUNC_DISCARD);
      else op(FUNC_COMMIT);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 4))
            0, 1: op(FUNC_GET);
            2: op(FUNC_RELEASE, 0, 0, 0, 0, 0, 4'($urandom_range(0, 5)));
            3: op(FUNC_TICK);
            default: op(FUNC_QUERY);
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: every function, header split across parts, limits, bad parts
      op(FUNC_ADD, 0, 0, 5, SOI_FIRST, SOI_SECOND);
      op(FUNC_COMMIT);
      op(FUNC_GET);
      op(FUNC_QUERY);
      op(FUNC_START, 32'hFFFF_FFFF);
      op(FUNC_ADD, 0, 0, 1, SOI_FIRST, 8'h00);
      op(FUNC_ADD, 0, 1, 1, SOI_SECOND, 8'hAA);
      op(FUNC_ADD, 0, 1, 1, 8'h00, 8'h00);
      op(FUNC_ADD, 0, PARTS, 4, 8'hFF, 8'hFF);
      op(FUNC_ADD, 0, 8'hFF, 4, 8'h00, 8'h00);
      op(FUNC_ADD, 0, 2, 0, 8'h00, 8'h00);
      op(FUNC_ADD, 0, 3, 20'hFFFFF, 8'hFF, 8'hFF);
      op(FUNC_ADD, 0, PARTS - 1, 7, 8'h00, 8'h00);
      op(FUNC_COMMIT);
      op(FUNC_START, 32'd10);
      op(FUNC_COMMIT);
      op(FUNC_START, 32'd11);
      op(FUNC_ADD, 0, 0, 9, SOI_FIRST, SOI_SECOND);
      op(FUNC_COMMIT);
      op(FUNC_GET);
      op(FUNC_GET);
      op(FUNC_RELEASE, 0, 0, 0, 0, 0, 4'hF);
      op(FUNC_DISCARD);
      op(FUNC_TICK);
      op(FUNC_QUERY);

      // every slot locked, then stale locks
      write_reg(CSR_TIMEOUT, 20'd1);
      write_reg(CSR_MAX_BYTES, 20'd2);
      for (int i = 0; i < SLOTS + 1; i++) begin
         op(FUNC_START, frame_seq);
         frame_seq++;
         op(FUNC_ADD, 0, 0, 2, SOI_FIRST, SOI_SECOND);
         op(FUNC_ADD, 0, 1, 1, SOI_FIRST, SOI_SECOND);
         op(FUNC_COMMIT);
         op(FUNC_GET);
      end
      repeat (3) op(FUNC_TICK);
      op(FUNC_START, frame_seq);
      write_reg(CSR_MAX_BYTES, 20'hFFFFF);
      write_reg(CSR_TIMEOUT, 20'hFFFF);

      while (sent < 280) begin
         if ($urandom_range(0, 7) == 0) random_noise();
         else random_frame();
      end
      write_reg(CSR_MAX_BYTES, 20'd700);
      write_reg(CSR_TIMEOUT, 20'd3);
      while (sent < 420) begin
         if ($urandom_range(0, 7) == 0) random_noise();
         else random_frame();
      end
      write_reg(CSR_MAX_BYTES, MAX_BYTES_RST);
      write_reg(CSR_TIMEOUT, 20'(TIMEOUT_RST));
      quiet_tail = 1;
      while (sent < 560) random_frame();

      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
